[sv/rse_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and GF(256) helpers for the Reed-Solomon encoder.
// No dependencies; used by every other file of the block.
package rse_pkg;

   localparam int          SYM_W           = 8;
   localparam int          CFG_W           = 6;
   localparam int          MAX_PARITY_DEF  = 32;
   localparam int          QUEUE_DEPTH_DEF = 4;
   localparam int          MIN_PARITY      = 2;
   localparam logic [CFG_W-1:0] RESET_PARITY = 6'd16;
   localparam logic [SYM_W-1:0] GF_POLY_LOW  = 8'h1d;  // x^8 + x^4 + x^3 + x^2 + 1
   localparam logic [SYM_W-1:0] SYM_MAX      = 8'd255;
   localparam logic [SYM_W-1:0] GF_ONE       = 8'd1;

   typedef struct packed {
      logic [SYM_W-1:0] data_symbol;
      logic             end_of_message;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] code_symbol;
      logic             is_parity;
      logic             last;
      logic             overlength;
   } rsp_type;

   // item as held in the queue between front and back
   typedef struct packed {
      req_type req;
      logic    sop;
   } q_item_type;

   // multiply by alpha
   function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] x);
      return {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? GF_POLY_LOW : '0);
   endfunction

   function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] x;
      logic [SYM_W-1:0] acc;
      x   = a;
      acc = '0;
      for (int k = 0; k < SYM_W; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      return acc;
   endfunction

endpackage

[sv/reed_solomon_systematic_encoder_core.sv]
`timescale 1ns / 1ps
// Top level of the systematic RS(255) encoder over GF(256), poly 0x11d.
// Latency: a data item is on the result ports in the cycle after it is taken; the first
//   byte after reset or a parity count change waits while g(x) is built.
// Throughput: one byte per cycle while results are popped; no byte is taken during
//   the g(x) build or the P-byte parity unload, or while the single output register is held.
// Reset (synchronous): queue, output and remainder cleared, parity count 16.
module reed_solomon_systematic_encoder_core #(
   parameter int MAX_PARITY  = rse_pkg::MAX_PARITY_DEF,
   parameter int QUEUE_DEPTH = rse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // item input, queue style
   input  logic                      push,
   output logic                      full,
   input  rse_pkg::req_type          req_payload,
   // result output, queue style
   output logic                      empty,
   input  logic                      pop,
   output rse_pkg::rsp_type          rsp_payload,
   // parity count register write
   input  logic                      valid,
   output logic                      ready,
   input  logic [rse_pkg::CFG_W-1:0] csr_wdata
);

   // parity count as written; values outside 2..MAX_PARITY are clamped by the
   // back end, and a new value only takes effect on the next message start
   logic [rse_pkg::CFG_W-1:0] csr_parity_ff, csr_parity_in;

   logic                q_valid;
   logic                q_pop;
   rse_pkg::q_item_type q_head;

   assign ready         = 1'b1;
   assign csr_parity_in = (valid && ready) ? csr_wdata : csr_parity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_parity_ff <= rse_pkg::RESET_PARITY;
      end else begin
         csr_parity_ff <= csr_parity_in;
      end
   end

   // front end: input queue, tags the first byte of each message
   rse_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   // back end: generator build, LFSR division, parity unload, output register
   rse_back #(
      .MAX_PARITY (MAX_PARITY)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .parity_count (csr_parity_ff),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_payload  (rsp_payload)
   );

   // final-byte flag only ever sits on a parity byte
   a_last_parity: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.last) |-> rsp_payload.is_parity)
      else $error("last flag on a data byte");

endmodule

[sv/rse_front.sv]
`timescale 1ns / 1ps
// Input side: takes items, marks the first byte of each message, queues them.
// Depends on rse_pkg.
module rse_front #(
   parameter int DEPTH = rse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  rse_pkg::req_type     req_payload,
   output logic                 q_valid,
   output rse_pkg::q_item_type  q_head,
   input  logic                 q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rse_pkg::q_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sop_ff, sop_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sop_in    = sop_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         sop_in    = req_payload.end_of_message;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sop_ff    <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sop_ff    <= sop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= '{req: req_payload, sop: sop_ff};
      end
   end

endmodule

[sv/rse_back.sv]
`timescale 1ns / 1ps
// Encoding engine: generator build, parity division register, parity unload
// and output register. Depends on rse_pkg.
module rse_back #(
   parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rse_pkg::CFG_W-1:0]     parity_count,
   input  logic                          q_valid,
   input  rse_pkg::q_item_type           q_head,
   output logic                          q_pop,
   output logic                          empty,
   input  logic                          pop,
   output rse_pkg::rsp_type              rsp_payload
);

   localparam int PW = $clog2(MAX_PARITY + 1);
   localparam int IW = $clog2(MAX_PARITY);
   localparam int SW = rse_pkg::SYM_W;

   typedef enum logic [2:0] {
      ST_RUN    = 3'b001,
      ST_BUILD  = 3'b010,
      ST_PARITY = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [SW-1:0]    gen_ff [MAX_PARITY+1];
   logic [SW-1:0]    gen_in [MAX_PARITY+1];
   logic [SW-1:0]    par_ff [MAX_PARITY];
   logic [SW-1:0]    par_in [MAX_PARITY];
   logic [SW-1:0]    prod   [MAX_PARITY+1];
   logic [SW-1:0]    root_ff, root_in;
   logic [PW-1:0]    active_ff, active_in;
   logic [PW-1:0]    step_ff, step_in;
   logic [SW-1:0]    sym_ff, sym_in;
   logic             over_ff, over_in;
   rse_pkg::rsp_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic [PW-1:0]    clamp_p;
   logic [IW-1:0]    top_idx;
   logic [SW-1:0]    fb;
   logic [SW-1:0]    mul_a;
   logic [SW-1:0]    sym_next;
   logic             over_now;
   logic             load_ok;
   logic             par_any;

   assign empty       = !out_valid_ff;
   assign rsp_payload = out_ff;
   assign load_ok     = !out_valid_ff || pop;

   always_comb begin
      if (parity_count < rse_pkg::CFG_W'(rse_pkg::MIN_PARITY)) begin
         clamp_p = PW'(rse_pkg::MIN_PARITY);
      end else if (parity_count > rse_pkg::CFG_W'(MAX_PARITY)) begin
         clamp_p = PW'(MAX_PARITY);
      end else begin
         clamp_p = PW'(parity_count);
      end
   end

   assign top_idx  = IW'(active_ff - 1'b1);
   assign fb       = q_head.req.data_symbol ^ par_ff[top_idx];
   assign mul_a    = (state_ff == ST_BUILD) ? root_ff : fb;
   assign sym_next = (sym_ff == rse_pkg::SYM_MAX) ? rse_pkg::SYM_MAX : sym_ff + 1'b1;
   assign over_now = ({1'b0, sym_next} + (SW + 1)'(active_ff)) > (SW + 1)'(rse_pkg::SYM_MAX);

   // one row of GF multipliers shared by generator build and encoding
   always_comb begin
      for (int k = 0; k <= MAX_PARITY; k++) begin
         prod[k] = rse_pkg::gf_mul(mul_a, gen_ff[k]);
      end
   end

   always_comb begin
      par_any = 1'b0;
      for (int k = 0; k < MAX_PARITY; k++) begin
         par_any = par_any | (par_ff[k] != '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      par_in       = par_ff;
      root_in      = root_ff;
      active_in    = active_ff;
      step_in      = step_ff;
      sym_in       = sym_ff;
      over_in      = over_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      q_pop        = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (q_valid) begin
               if (q_head.sop && (clamp_p != active_ff)) begin
                  // new parity count: rebuild g(x) from 1
                  state_in  = ST_BUILD;
                  active_in = clamp_p;
                  for (int k = 0; k <= MAX_PARITY; k++) begin
                     gen_in[k] = '0;
                  end
                  gen_in[0] = rse_pkg::GF_ONE;
                  root_in   = rse_pkg::GF_ONE;
                  step_in   = '0;
               end else if (load_ok) begin
                  q_pop = 1'b1;
                  for (int k = 1; k < MAX_PARITY; k++) begin
                     if (PW'(k) < active_ff) begin
                        par_in[k] = par_ff[k-1] ^ prod[k];
                     end
                  end
                  par_in[0]    = prod[0];
                  out_in       = '{code_symbol: q_head.req.data_symbol, is_parity: 1'b0,
                                   last: 1'b0, overlength: over_now};
                  out_valid_in = 1'b1;
                  over_in      = over_now;
                  step_in      = '0;
                  if (q_head.req.end_of_message) begin
                     sym_in   = '0;
                     state_in = ST_PARITY;
                  end else begin
                     sym_in = sym_next;
                  end
               end
            end
         end
         ST_BUILD: begin
            // multiply by (x + root), all coefficients at once
            for (int k = 1; k <= MAX_PARITY; k++) begin
               gen_in[k] = gen_ff[k-1] ^ prod[k];
            end
            gen_in[0] = prod[0];
            root_in   = rse_pkg::gf_xtime(root_ff);
            step_in   = step_ff + 1'b1;
            if (step_ff == active_ff - 1'b1) begin
               state_in = ST_RUN;
            end
         end
         ST_PARITY: begin
            if (load_ok) begin
               out_in       = '{code_symbol: par_ff[top_idx], is_parity: 1'b1,
                                last: (step_ff == active_ff - 1'b1), overlength: over_ff};
               out_valid_in = 1'b1;
               for (int k = 1; k < MAX_PARITY; k++) begin
                  if (PW'(k) < active_ff) begin
                     par_in[k] = par_ff[k-1];
                  end
               end
               par_in[0] = '0;
               step_in   = step_ff + 1'b1;
               if (step_ff == active_ff - 1'b1) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         active_ff    <= '0;     // nothing built yet: first message builds g(x)
         step_ff      <= '0;
         sym_ff       <= '0;
         over_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_PARITY; k++) begin
            par_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
         sym_ff       <= sym_in;
         over_ff      <= over_in;
         out_valid_ff <= out_valid_in;
         par_ff       <= par_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff  <= gen_in;
      root_ff <= root_in;
      out_ff  <= out_in;
   end

   a_gen_monic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && $past(state_ff) == ST_BUILD)
         |-> gen_ff[active_ff] == rse_pkg::GF_ONE)
      else $error("generator not monic after build");

   a_par_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && $past(state_ff) == ST_PARITY) |-> !par_any)
      else $error("remainder not cleared after parity unload");

   a_p_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PARITY) |=> $stable(active_ff))
      else $error("parity count changed during unload");

endmodule
